### rtl/wat_pkg.sv
// Shared types and constants for the weekday alarm table.
package wat_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_DELETE = 3'd2;
    localparam logic [2:0] MODE_TOGGLE = 3'd3;
    localparam logic [2:0] MODE_POLL   = 3'd4;

    localparam logic [7:0] DEFAULT_KEY  = 8'd1;
    localparam logic [4:0] DEFAULT_HOUR = 5'd7;
    localparam logic [6:0] DEFAULT_DAYS = 7'h3E;
    localparam logic [5:0] NO_MINUTE    = 6'd63;

    typedef struct packed {
        logic [7:0] key;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       enable;
        logic [6:0] days;
    } entry_t;

    localparam entry_t DEFAULT_ENTRY = '{
        key: DEFAULT_KEY, hour: DEFAULT_HOUR, minute: 6'd0, enable: 1'b0, days: DEFAULT_DAYS
    };

    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] weekday;
        logic [7:0] alarm_id;
        logic       enable_flag;
        logic [6:0] day_mask;
    } item_t;

    typedef struct packed {
        logic       op_ok;
        logic       fired;
        logic       pending_valid;
        logic [7:0] pending_id;
    } result_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic [IDX_W-1:0] rd_addr;
    } table_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIND,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

### rtl/wat_table.sv
// Alarm entry storage with one read port and one write port.
module wat_table (
    input  logic                clk,
    input  logic                rst_n,
    input  wat_pkg::table_req_t req,
    output wat_pkg::entry_t     rd_data
);

    wat_pkg::entry_t mem [wat_pkg::MAX_ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < wat_pkg::MAX_ENTRIES; i++)
            begin
                mem[wat_pkg::IDX_W'(i)] <= (i == 0) ? wat_pkg::DEFAULT_ENTRY
                                                    : wat_pkg::entry_t'('0);
            end
        end
        else if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    assign rd_data = mem[req.rd_addr];

endmodule

### rtl/wat_ctrl.sv
// Sequencer that scans, searches and compacts the alarm table one entry per cycle.
module wat_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  wat_pkg::item_t       item,
    input  logic                 out_free,
    input  wat_pkg::entry_t      rd_data,
    output wat_pkg::table_req_t  req,
    output logic                 busy,
    output logic                 done,
    output wat_pkg::result_t     result
);

    wat_pkg::state_t                state_reg, state_next;
    wat_pkg::item_t                 item_reg, item_next;
    logic [wat_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [wat_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [5:0]                     last_min_reg, last_min_next;
    logic                           pend_flag_reg, pend_flag_next;
    logic [7:0]                     pend_key_reg, pend_key_next;
    logic                           ok_reg, ok_next;
    logic                           fired_reg, fired_next;
    logic                           polled_reg, polled_next;
    logic [7:0]                     poll_id_reg, poll_id_next;

    logic [wat_pkg::CNT_W-1:0]      idx_ext;
    logic                           last_idx;
    logic [7:0]                     today;
    logic                           time_hit;
    logic                           day_hit;
    logic                           key_hit;

    assign idx_ext  = wat_pkg::CNT_W'(idx_reg);
    assign last_idx = (idx_ext + wat_pkg::CNT_W'(1)) >= count_reg;
    assign today    = 8'd1 << item_reg.weekday;
    assign time_hit = rd_data.enable && (rd_data.hour == item_reg.hour)
                      && (rd_data.minute == item_reg.minute);
    assign day_hit  = (rd_data.days == 7'd0) || ((rd_data.days & today[6:0]) != 7'd0);
    assign key_hit  = (idx_ext < count_reg) && (rd_data.key == item_reg.alarm_id);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wat_pkg::S_IDLE;
            count_reg     <= wat_pkg::CNT_W'(1);
            last_min_reg  <= wat_pkg::NO_MINUTE;
            pend_flag_reg <= 1'b0;
            pend_key_reg  <= 8'd0;
            idx_reg       <= '0;
            ok_reg        <= 1'b0;
            fired_reg     <= 1'b0;
            polled_reg    <= 1'b0;
            poll_id_reg   <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_min_reg  <= last_min_next;
            pend_flag_reg <= pend_flag_next;
            pend_key_reg  <= pend_key_next;
            idx_reg       <= idx_next;
            ok_reg        <= ok_next;
            fired_reg     <= fired_next;
            polled_reg    <= polled_next;
            poll_id_reg   <= poll_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        last_min_next  = last_min_reg;
        pend_flag_next = pend_flag_reg;
        pend_key_next  = pend_key_reg;
        ok_next        = ok_reg;
        fired_next     = fired_reg;
        polled_next    = polled_reg;
        poll_id_next   = poll_id_reg;
        req.wr_en      = 1'b0;
        req.wr_addr    = idx_reg;
        req.wr_data    = rd_data;
        req.rd_addr    = idx_reg;
        done           = 1'b0;

        case (state_reg)
            wat_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_next    = item;
                    idx_next     = '0;
                    ok_next      = 1'b0;
                    fired_next   = 1'b0;
                    polled_next  = 1'b0;
                    poll_id_next = 8'd0;
                    case (item.mode)
                        wat_pkg::MODE_TICK:
                        begin
                            if (item.minute == last_min_reg || count_reg == '0)
                            begin
                                state_next = wat_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = wat_pkg::S_SCAN;
                            end
                            last_min_next = item.minute;
                        end
                        wat_pkg::MODE_ADD, wat_pkg::MODE_DELETE, wat_pkg::MODE_TOGGLE:
                        begin
                            state_next = wat_pkg::S_FIND;
                        end
                        wat_pkg::MODE_POLL:
                        begin
                            polled_next = 1'b1;
                            if (pend_flag_reg)
                            begin
                                ok_next        = 1'b1;
                                poll_id_next   = pend_key_reg;
                                pend_flag_next = 1'b0;
                                pend_key_next  = 8'd0;
                            end
                            state_next = wat_pkg::S_DONE;
                        end
                        default:
                        begin
                            state_next = wat_pkg::S_DONE;
                        end
                    endcase
                end
            end

            wat_pkg::S_SCAN:
            begin
                if (time_hit && day_hit)
                begin
                    fired_next     = 1'b1;
                    pend_flag_next = 1'b1;
                    pend_key_next  = rd_data.key;
                end
                if (last_idx)
                begin
                    state_next = wat_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + wat_pkg::IDX_W'(1);
                end
            end

            wat_pkg::S_FIND:
            begin
                if (key_hit)
                begin
                    ok_next    = 1'b1;
                    state_next = wat_pkg::S_DONE;
                    case (item_reg.mode)
                        wat_pkg::MODE_ADD:
                        begin
                            req.wr_en   = 1'b1;
                            req.wr_data = '{key: item_reg.alarm_id, hour: item_reg.hour,
                                            minute: item_reg.minute,
                                            enable: item_reg.enable_flag,
                                            days: item_reg.day_mask};
                        end
                        wat_pkg::MODE_TOGGLE:
                        begin
                            req.wr_en          = 1'b1;
                            req.wr_data.enable = ~rd_data.enable;
                        end
                        default:
                        begin
                            if (last_idx)
                            begin
                                count_next = count_reg - wat_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                state_next = wat_pkg::S_SHIFT;
                            end
                        end
                    endcase
                end
                else if (last_idx)
                begin
                    state_next = wat_pkg::S_DONE;
                    if (item_reg.mode == wat_pkg::MODE_ADD
                        && count_reg < wat_pkg::CNT_W'(wat_pkg::MAX_ENTRIES))
                    begin
                        ok_next     = 1'b1;
                        req.wr_en   = 1'b1;
                        req.wr_addr = wat_pkg::IDX_W'(count_reg);
                        req.wr_data = '{key: item_reg.alarm_id, hour: item_reg.hour,
                                        minute: item_reg.minute,
                                        enable: item_reg.enable_flag,
                                        days: item_reg.day_mask};
                        count_next  = count_reg + wat_pkg::CNT_W'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + wat_pkg::IDX_W'(1);
                end
            end

            wat_pkg::S_SHIFT:
            begin
                req.rd_addr = idx_reg + wat_pkg::IDX_W'(1);
                req.wr_en   = 1'b1;
                if ((idx_ext + wat_pkg::CNT_W'(2)) >= count_reg)
                begin
                    count_next = count_reg - wat_pkg::CNT_W'(1);
                    state_next = wat_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + wat_pkg::IDX_W'(1);
                end
            end

            wat_pkg::S_DONE:
            begin
                done = 1'b1;
                if (out_free)
                begin
                    state_next = wat_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wat_pkg::S_IDLE;
            end
        endcase
    end

    assign busy                 = (state_reg != wat_pkg::S_IDLE);
    assign result.op_ok         = ok_reg;
    assign result.fired         = fired_reg;
    assign result.pending_valid = pend_flag_reg;
    assign result.pending_id    = polled_reg ? poll_id_reg
                                             : (pend_flag_reg ? pend_key_reg : 8'd0);

endmodule

### rtl/weekday_alarm_table_top.sv
// Top level of the weekday alarm table: input handshake, sequencer, storage and output register.
//
// The input channel carries one command per transaction (tick, add or update, delete,
// toggle, poll). Every command produces exactly one result transaction on the output
// channel. A transaction is taken when valid is high and stall is low.
// The block works on one command at a time and holds in_stall high while it does.
// What each command does after acceptance, with N stored entries:
//   poll, unused mode, a tick of an already checked minute or an empty table: no table visit;
//   tick: all N entries compared, one entry compared per cycle;
//   add, toggle: a key search over up to N entries;
//   delete: key search, then the entries behind the found one are moved down
//   one by one to close the gap.
// in_stall falls as out_valid rises, so a command occupies the block until its result
// is presented. The single table read port, visited once per cycle, paces the search.
// A finished result sits in an output register; the next command is accepted while
// it waits, but that command is not completed until the receiver takes the result.
// When out_stall is high the result and out_valid hold steady. After reset the table
// holds one disabled alarm (key 1, 07:00, Monday to Friday), no minute has been
// checked and nothing is pending.
module weekday_alarm_table_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] mode,
    input  logic [4:0] hour,
    input  logic [5:0] minute,
    input  logic [2:0] weekday,
    input  logic [7:0] alarm_id,
    input  logic       enable_flag,
    input  logic [6:0] day_mask,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       op_ok,
    output logic       fired,
    output logic       pending_valid,
    output logic [7:0] pending_id
);

    wat_pkg::item_t      item;
    wat_pkg::table_req_t req;
    wat_pkg::entry_t     rd_data;
    wat_pkg::result_t    result;
    wat_pkg::result_t    result_reg;
    logic                out_valid_reg, out_valid_next;
    logic                busy;
    logic                done;
    logic                start;
    logic                out_free;

    assign item = '{mode: mode, hour: hour, minute: minute, weekday: weekday,
                    alarm_id: alarm_id, enable_flag: enable_flag, day_mask: day_mask};

    assign in_stall = busy;
    assign start    = in_valid && !busy;
    assign out_free = !out_valid_reg || !out_stall;

    wat_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (rd_data)
    );

    wat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .out_free (out_free),
        .rd_data  (rd_data),
        .req      (req),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign op_ok         = result_reg.op_ok;
    assign fired         = result_reg.fired;
    assign pending_valid = result_reg.pending_valid;
    assign pending_id    = result_reg.pending_id;

endmodule

### sim/weekday_alarm_table_top_test.sv
// Self-checking testbench for the weekday alarm table: random and directed commands with a predictor.
module weekday_alarm_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1750;
    localparam int DIRECTED_ITEMS = 25;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    wat_pkg::item_t drive_cmd = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic op_ok;
    logic fired;
    logic pending_valid;
    logic [7:0] pending_id;

    wat_pkg::item_t command_queue[$];
    wat_pkg::result_t expected_results[$];
    int total_commands = 1;
    int sent_count = 0;
    int fail_count = 0;
    int cycle_count = 0;

    bit key_present[256];
    int key_total = 1;

    wat_pkg::entry_t alarm_table[wat_pkg::MAX_ENTRIES];
    int alarm_count;
    logic [5:0] last_minute;
    logic pend_flag;
    logic [7:0] pend_key;

    always #1 clk = ~clk;

    weekday_alarm_table_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(drive_cmd.mode),
        .hour(drive_cmd.hour),
        .minute(drive_cmd.minute),
        .weekday(drive_cmd.weekday),
        .alarm_id(drive_cmd.alarm_id),
        .enable_flag(drive_cmd.enable_flag),
        .day_mask(drive_cmd.day_mask),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .op_ok(op_ok),
        .fired(fired),
        .pending_valid(pending_valid),
        .pending_id(pending_id)
    );

    function automatic int idle_phase();
        return (sent_count * 3) / total_commands;
    endfunction

    function automatic int send_idle_pct();
        case (idle_phase())
            0: return 27;
            1: return 84;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_idle_pct();
        case (idle_phase())
            0: return 84;
            1: return 27;
            default: return 0;
        endcase
    endfunction

    function automatic void reset_alarm_table();
        foreach (alarm_table[i])
        begin
            alarm_table[i] = '0;
        end
        alarm_table[0] = wat_pkg::DEFAULT_ENTRY;
        alarm_count = 1;
        last_minute = wat_pkg::NO_MINUTE;
        pend_flag = 1'b0;
        pend_key = '0;
    endfunction

    function automatic int find_alarm(logic [7:0] id);
        for (int i = 0; i < alarm_count; i++)
        begin
            if (alarm_table[i].key == id)
            begin
                return i;
            end
        end
        return alarm_count;
    endfunction

    function automatic wat_pkg::result_t apply_command(wat_pkg::item_t c);
        wat_pkg::result_t r;
        wat_pkg::entry_t e;
        logic [7:0] today;
        logic [7:0] poll_key;
        bit polled;
        int slot;
        r = '0;
        poll_key = '0;
        polled = 1'b0;
        today = 8'd1 << c.weekday;
        e = '{key: c.alarm_id, hour: c.hour, minute: c.minute, enable: c.enable_flag,
              days: c.day_mask};
        slot = find_alarm(c.alarm_id);
        case (c.mode)
            wat_pkg::MODE_TICK:
            begin
                if (c.minute != last_minute)
                begin
                    last_minute = c.minute;
                    for (int i = 0; i < alarm_count; i++)
                    begin
                        if (alarm_table[i].enable && alarm_table[i].hour == c.hour
                            && alarm_table[i].minute == c.minute
                            && (alarm_table[i].days == '0
                                || ({1'b0, alarm_table[i].days} & today) != '0))
                        begin
                            r.fired = 1'b1;
                            pend_flag = 1'b1;
                            pend_key = alarm_table[i].key;
                        end
                    end
                end
            end
            wat_pkg::MODE_ADD:
            begin
                if (slot < alarm_count)
                begin
                    alarm_table[slot] = e;
                    r.op_ok = 1'b1;
                end
                else if (alarm_count < wat_pkg::MAX_ENTRIES)
                begin
                    alarm_table[alarm_count] = e;
                    alarm_count++;
                    r.op_ok = 1'b1;
                end
            end
            wat_pkg::MODE_DELETE:
            begin
                if (slot < alarm_count)
                begin
                    for (int i = slot; i + 1 < alarm_count; i++)
                    begin
                        alarm_table[i] = alarm_table[i + 1];
                    end
                    alarm_count--;
                    r.op_ok = 1'b1;
                end
            end
            wat_pkg::MODE_TOGGLE:
            begin
                if (slot < alarm_count)
                begin
                    alarm_table[slot].enable = ~alarm_table[slot].enable;
                    r.op_ok = 1'b1;
                end
            end
            wat_pkg::MODE_POLL:
            begin
                polled = 1'b1;
                if (pend_flag)
                begin
                    r.op_ok = 1'b1;
                    poll_key = pend_key;
                    pend_flag = 1'b0;
                    pend_key = '0;
                end
            end
            default:
            begin
            end
        endcase
        r.pending_valid = pend_flag;
        r.pending_id = polled ? poll_key : (pend_flag ? pend_key : 8'd0);
        return r;
    endfunction

    function automatic void push_cmd(logic [2:0] md, logic [4:0] hr, logic [5:0] mn,
                                     logic [2:0] wd, logic [7:0] id, logic en, logic [6:0] dm);
        wat_pkg::item_t c;
        c = '{mode: md, hour: hr, minute: mn, weekday: wd, alarm_id: id, enable_flag: en,
              day_mask: dm};
        command_queue.push_back(c);
        if (md == wat_pkg::MODE_ADD && !key_present[id] && key_total < wat_pkg::MAX_ENTRIES)
        begin
            key_present[id] = 1'b1;
            key_total++;
        end
        else if (md == wat_pkg::MODE_DELETE && key_present[id])
        begin
            key_present[id] = 1'b0;
            key_total--;
        end
    endfunction

    function automatic logic [7:0] pick_known_key();
        int start;
        start = $urandom_range(0, 255);
        for (int i = 0; i < 256; i++)
        begin
            if (key_present[8'(start + i)])
            begin
                return 8'(start + i);
            end
        end
        return 8'(start);
    endfunction

    function automatic logic [4:0] rand_hour();
        return ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
    endfunction

    function automatic logic [5:0] rand_minute();
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [2:0] rand_weekday();
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] rand_key();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [6:0] rand_mask();
        return 7'($urandom_range(0, 127));
    endfunction

    function automatic logic [6:0] rand_days();
        return ($urandom_range(0, 3) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
    endfunction

    function automatic void check_field(string name, logic [7:0] expected, logic [7:0] actual);
        if (expected !== actual)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver
        bit advance;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            reset_alarm_table();
        end
        else
        begin
            advance = !in_valid;
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(apply_command(drive_cmd));
                advance = 1'b1;
            end
            if (advance)
            begin
                if (command_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct())
                begin
                    drive_cmd <= command_queue.pop_front();
                    in_valid <= 1'b1;
                    sent_count <= sent_count + 1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        wat_pkg::result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no command outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("op_ok", 8'(want.op_ok), 8'(op_ok));
                    check_field("fired", 8'(want.fired), 8'(fired));
                    check_field("pending_valid", 8'(want.pending_valid), 8'(pending_valid));
                    check_field("pending_id", want.pending_id, pending_id);
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** weekday_alarm_table_top: FAILED **");
        $finish;
    end

    initial
    begin
        logic [4:0] h;
        logic [5:0] m;
        logic [7:0] k;
        int sel;
        key_present[wat_pkg::DEFAULT_KEY] = 1'b1;

        push_cmd(wat_pkg::MODE_POLL, 5'd0, 6'd0, 3'd0, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_TICK, 5'd7, 6'd63, 3'd1, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_TOGGLE, 5'd0, 6'd0, 3'd0, wat_pkg::DEFAULT_KEY, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_TICK, 5'd7, 6'd0, 3'd1, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_TICK, 5'd7, 6'd0, 3'd1, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_POLL, 5'd0, 6'd0, 3'd0, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_POLL, 5'd0, 6'd0, 3'd0, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_ADD, 5'd31, 6'd63, 3'd0, 8'd255, 1'b1, 7'd0);
        push_cmd(wat_pkg::MODE_TICK, 5'd31, 6'd63, 3'd7, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_ADD, 5'd31, 6'd63, 3'd0, 8'd0, 1'b1, 7'h7F);
        push_cmd(wat_pkg::MODE_TICK, 5'd31, 6'd62, 3'd0, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_TICK, 5'd31, 6'd63, 3'd7, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_ADD, 5'd31, 6'd63, 3'd0, 8'd255, 1'b1, 7'h40);
        push_cmd(wat_pkg::MODE_TICK, 5'd31, 6'd62, 3'd6, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_TICK, 5'd31, 6'd63, 3'd6, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_POLL, 5'd0, 6'd0, 3'd0, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_TOGGLE, 5'd0, 6'd0, 3'd0, 8'd200, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_DELETE, 5'd0, 6'd0, 3'd0, 8'd200, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_DELETE, 5'd0, 6'd0, 3'd0, wat_pkg::DEFAULT_KEY, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_TOGGLE, 5'd0, 6'd0, 3'd0, 8'd0, 1'b0, 7'd0);
        push_cmd(MODE_SPARE_LO, 5'd0, 6'd0, 3'd0, 8'd0, 1'b0, 7'd0);
        push_cmd(MODE_SPARE_HI, 5'd31, 6'd63, 3'd7, 8'd255, 1'b1, 7'h7F);
        push_cmd(wat_pkg::MODE_TICK, 5'd0, 6'd0, 3'd0, 8'd0, 1'b0, 7'd0);
        push_cmd(wat_pkg::MODE_ADD, 5'd0, 6'd0, 3'd0, 8'd128, 1'b0, 7'd1);

        while (command_queue.size() < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                repeat (wat_pkg::MAX_ENTRIES + 2)
                begin
                    push_cmd(wat_pkg::MODE_ADD, rand_hour(), rand_minute(), rand_weekday(),
                             rand_key(), rand_bit(), rand_mask());
                end
            end
            else if (sel < 13)
            begin
                while (key_total > 0)
                begin
                    push_cmd(wat_pkg::MODE_DELETE, rand_hour(), rand_minute(), rand_weekday(),
                             pick_known_key(), rand_bit(), rand_mask());
                end
                push_cmd(wat_pkg::MODE_TICK, rand_hour(), rand_minute(), rand_weekday(),
                         rand_key(), rand_bit(), rand_mask());
                push_cmd(wat_pkg::MODE_POLL, rand_hour(), rand_minute(), rand_weekday(),
                         rand_key(), rand_bit(), rand_mask());
            end
            else if (sel < 50)
            begin
                h = rand_hour();
                m = rand_minute();
                k = $urandom_range(0, 1) ? pick_known_key() : rand_key();
                push_cmd(wat_pkg::MODE_ADD, h, m, rand_weekday(), k, $urandom_range(0, 5) != 0,
                         rand_days());
                if ($urandom_range(0, 2) == 0)
                begin
                    push_cmd(wat_pkg::MODE_ADD, h, m, rand_weekday(), rand_key(),
                             $urandom_range(0, 5) != 0, rand_days());
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    push_cmd(wat_pkg::MODE_TOGGLE, h, m, rand_weekday(), k, rand_bit(),
                             rand_mask());
                end
                push_cmd(wat_pkg::MODE_TICK, h, m + 6'd1, rand_weekday(), rand_key(),
                         rand_bit(), rand_mask());
                push_cmd(wat_pkg::MODE_TICK, h, m, rand_weekday(), rand_key(),
                         rand_bit(), rand_mask());
                if ($urandom_range(0, 1) == 0)
                begin
                    push_cmd(wat_pkg::MODE_POLL, rand_hour(), rand_minute(), rand_weekday(),
                             rand_key(), rand_bit(), rand_mask());
                end
            end
            else
            begin
                sel = $urandom_range(0, 99);
                k = $urandom_range(0, 9) < 6 ? pick_known_key() : rand_key();
                push_cmd(sel < 25 ? wat_pkg::MODE_TICK : sel < 45 ? wat_pkg::MODE_ADD
                         : sel < 58 ? wat_pkg::MODE_DELETE
                         : sel < 70 ? wat_pkg::MODE_TOGGLE : sel < 92 ? wat_pkg::MODE_POLL
                         : 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)),
                         5'($urandom_range(0, 31)), rand_minute(), rand_weekday(), k,
                         rand_bit(), rand_mask());
            end
        end
        total_commands = command_queue.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (command_queue.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
        begin
            $display("** weekday_alarm_table_top: PASSED **");
        end
        else
        begin
            $display("** weekday_alarm_table_top: FAILED **");
        end
        $finish;
    end

endmodule
